### sv/zfe_pkg.sv
// Shared types and constants for the zero-forcing SISO equalizer.
// Depends on nothing; the top level and zfe_div_stage import it.
`timescale 1ns / 1ps
`default_nettype none
package zfe_pkg;

  localparam int ADDR_W = 3;
  localparam logic [15:0] GAIN_RESET = 16'd4096;

  // register index codes (paddr[2])
  localparam logic REG_NOISE_VAR = 1'b0;
  localparam logic REG_TX_GAIN   = 1'b1;

  localparam int QS    = 17;  // sample quotient bits (one extra for rounding)
  localparam int QN    = 33;  // noise quotient bits (one extra for rounding)
  localparam int STEPS = 33;  // divider stages
  localparam int D_W   = 48;  // tx_gain * |c|^2
  localparam int DR_W  = 49;  // sample remainder
  localparam int DN_W  = 64;  // tx_gain^2 * |c|^2
  localparam int NR_W  = 65;  // noise remainder

  typedef struct packed {
    logic              valid;
    logic              null_ch;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic              ovf_nv;
    logic [DR_W-1:0]   r_re;
    logic [DR_W-1:0]   r_im;
    logic [D_W-1:0]    d;
    logic [NR_W-1:0]   r_nv;
    logic [DN_W-1:0]   dn;
    logic [QS-1:0]     q_re;
    logic [QS-1:0]     q_im;
    logic [QN-1:0]     q_nv;
  } div_t;

  // Round half away from zero and saturate a sample quotient to 16 bits.
  function automatic logic [15:0] sat_s16(input logic neg, input logic ovf,
                                          input logic [QS-1:0] q2);
    logic [QS:0]   rnd;
    logic [QS-1:0] mag;
    begin
      rnd = ({1'b0, q2} + {{QS{1'b0}}, 1'b1}) >> 1;
      if (neg) begin
        if (ovf || rnd > (QS+1)'(32768)) mag = QS'(32768);
        else mag = rnd[QS-1:0];
        sat_s16 = 16'(-mag);
      end else begin
        if (ovf || rnd > (QS+1)'(32767)) mag = QS'(32767);
        else mag = rnd[QS-1:0];
        sat_s16 = mag[15:0];
      end
    end
  endfunction

  function automatic logic [31:0] sat_u32(input logic ovf, input logic [QN-1:0] q2);
    logic [QN:0] rnd;
    begin
      rnd = ({1'b0, q2} + {{QN{1'b0}}, 1'b1}) >> 1;
      if (ovf || rnd[QN:QN-1] != 2'b00) sat_u32 = 32'hFFFF_FFFF;
      else sat_u32 = rnd[31:0];
    end
  endfunction

endpackage
`default_nettype wire

### sv/zfe_if.sv
// Valid/ready channel interfaces for the equalizer input and output.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface zfe_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rx_re;
  logic signed [15:0] rx_im;
  logic signed [15:0] chan_re;
  logic signed [15:0] chan_im;
  modport source(output valid, rx_re, rx_im, chan_re, chan_im, input ready);
  modport sink(input valid, rx_re, rx_im, chan_re, chan_im, output ready);
endinterface

interface zfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] eq_re;
  logic signed [15:0] eq_im;
  logic [31:0]        eq_noise_var;
  logic               null_channel;
  modport source(output valid, eq_re, eq_im, eq_noise_var, null_channel, input ready);
  modport sink(input valid, eq_re, eq_im, eq_noise_var, null_channel, output ready);
endinterface
`default_nettype wire

### sv/zero_forcing_siso_equalizer.sv
// Zero-forcing SISO equalizer top level: APB registers, multiplier front end,
// pipelined divider and output register. Depends on zfe_pkg, zfe_if, zfe_div_stage.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    rx_re, rx_im, chan_re, chan_im (Q1.15)
//  out_ch    out  valid/ready    eq_re, eq_im (Q5.11), eq_noise_var (Q16.16), null_channel
//  apb       in   psel/penable   noise_variance @0x0, tx_gain @0x4
//
// One beat per cycle in, one out, while out_ch is not stalled. Pipeline: 3 multiply/sum stages,
// a divider setup stage, 33 division steps (one quotient bit each) and the
// output register. The 33-step noise divide sets the depth.
// Reset (rst, synchronous) clears all valid bits and noise_variance, and loads tx_gain with GAIN_RESET.
// A stall at out_ch freezes the whole pipe; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module zero_forcing_siso_equalizer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [zfe_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  zfe_in_if.sink                          in_ch,
  zfe_out_if.source                       out_ch
);
  import zfe_pkg::*;

  logic [31:0] noise_variance;
  logic [15:0] tx_gain;
  logic        en;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TX_GAIN) ? {16'b0, tx_gain} : noise_variance;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_variance <= '0;
      tx_gain        <= GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_NOISE_VAR) noise_variance <= pwdata;
      else tx_gain <= pwdata[15:0];
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: products
  logic               v1;
  logic signed [31:0] m_rr, m_ii, m_ir, m_ri, m_cc, m_dd;
  logic [31:0]        gg1;
  logic [15:0]        g1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_rr <= in_ch.rx_re * in_ch.chan_re;
      m_ii <= in_ch.rx_im * in_ch.chan_im;
      m_ir <= in_ch.rx_im * in_ch.chan_re;
      m_ri <= in_ch.rx_re * in_ch.chan_im;
      m_cc <= in_ch.chan_re * in_ch.chan_re;
      m_dd <= in_ch.chan_im * in_ch.chan_im;
      gg1  <= tx_gain * tx_gain;
      g1   <= tx_gain;
    end
  end

  // stage 2: sums
  logic               v2, null2;
  logic signed [32:0] pr2, pi2;
  logic [31:0]        mc2, gg2;
  logic [15:0]        g2;
  logic [31:0]        mc_sum;

  assign mc_sum = 32'(m_cc) + 32'(m_dd);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pr2   <= 33'(m_rr) + 33'(m_ii);
      pi2   <= 33'(m_ir) - 33'(m_ri);
      mc2   <= mc_sum;
      gg2   <= gg1;
      g2    <= g1;
      null2 <= (g1 == 16'd0) || (mc_sum == 32'd0);
    end
  end

  // stage 3: divisors and magnitudes
  logic              v3, null3, neg_re3, neg_im3;
  logic [31:0]       mag_re3, mag_im3;
  logic [D_W-1:0]    d3;
  logic [DN_W-1:0]   dn3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d3      <= g2 * mc2;
      dn3     <= gg2 * mc2;
      neg_re3 <= pr2[32];
      neg_im3 <= pi2[32];
      mag_re3 <= pr2[32] ? 32'(-pr2) : 32'(pr2);
      mag_im3 <= pi2[32] ? 32'(-pi2) : 32'(pi2);
      null3   <= null2;
    end
  end

  // stage 4: divider setup; overflow when the quotient cannot fit
  div_t            dv [0:STEPS];
  logic [DR_W-1:0] r0_re, r0_im;
  logic [NR_W-1:0] r0_nv;

  assign r0_re = {10'b0, mag_re3, 7'b0};
  assign r0_im = {10'b0, mag_im3, 7'b0};
  assign r0_nv = {11'b0, noise_variance, 22'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0].valid   <= v3;
      dv[0].null_ch <= null3;
      dv[0].neg_re  <= neg_re3;
      dv[0].neg_im  <= neg_im3;
      dv[0].ovf_re  <= r0_re >= {1'b0, d3};
      dv[0].ovf_im  <= r0_im >= {1'b0, d3};
      dv[0].ovf_nv  <= r0_nv >= {1'b0, dn3};
      dv[0].r_re    <= r0_re;
      dv[0].r_im    <= r0_im;
      dv[0].r_nv    <= r0_nv;
      dv[0].d       <= d3;
      dv[0].dn      <= dn3;
      dv[0].q_re    <= '0;
      dv[0].q_im    <= '0;
      dv[0].q_nv    <= '0;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_div
    zfe_div_stage #(
      .SAMPLE_ON((s >= STEPS - QS) ? 1 : 0)
    ) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (dv[s]),
      .d_out (dv[s+1])
    );
  end

  // output register: round, saturate, force zero on a null channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= dv[STEPS].valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv[STEPS].null_ch) begin
        out_ch.eq_re        <= '0;
        out_ch.eq_im        <= '0;
        out_ch.eq_noise_var <= '0;
        out_ch.null_channel <= 1'b1;
      end else begin
        out_ch.eq_re        <= sat_s16(dv[STEPS].neg_re, dv[STEPS].ovf_re, dv[STEPS].q_re);
        out_ch.eq_im        <= sat_s16(dv[STEPS].neg_im, dv[STEPS].ovf_im, dv[STEPS].q_im);
        out_ch.eq_noise_var <= sat_u32(dv[STEPS].ovf_nv, dv[STEPS].q_nv);
        out_ch.null_channel <= 1'b0;
      end
    end
  end

  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.null_channel |->
      out_ch.eq_re == 16'sd0 && out_ch.eq_im == 16'sd0 && out_ch.eq_noise_var == 32'd0)
    else $error("null channel beat carries nonzero payload");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready disagrees with output stall");

  a_divisor: assert property (@(posedge clk) disable iff (rst)
    v3 && d3 == '0 |-> null3)
    else $error("zero divisor not flagged as null channel");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv[STEPS]))
    else $error("divider output moved during stall");

endmodule
`default_nettype wire

### sv/zfe_div_stage.sv
// One restoring-division step for the noise quotient and, when SAMPLE_ON is set, the sample quotients.
// Depends on zfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zfe_div_stage #(
  parameter int SAMPLE_ON = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire zfe_pkg::div_t d_in,
  output zfe_pkg::div_t     d_out
);
  import zfe_pkg::*;

  div_t            nxt;
  logic [DR_W-1:0] sh_re;
  logic [DR_W-1:0] sh_im;
  logic [NR_W-1:0] sh_nv;

  always_comb begin
    nxt   = d_in;
    sh_re = d_in.r_re << 1;
    sh_im = d_in.r_im << 1;
    sh_nv = d_in.r_nv << 1;
    if (SAMPLE_ON != 0) begin
      if (sh_re >= {1'b0, d_in.d}) begin
        nxt.r_re = sh_re - {1'b0, d_in.d};
        nxt.q_re = {d_in.q_re[QS-2:0], 1'b1};
      end else begin
        nxt.r_re = sh_re;
        nxt.q_re = {d_in.q_re[QS-2:0], 1'b0};
      end
      if (sh_im >= {1'b0, d_in.d}) begin
        nxt.r_im = sh_im - {1'b0, d_in.d};
        nxt.q_im = {d_in.q_im[QS-2:0], 1'b1};
      end else begin
        nxt.r_im = sh_im;
        nxt.q_im = {d_in.q_im[QS-2:0], 1'b0};
      end
    end
    if (sh_nv >= {1'b0, d_in.dn}) begin
      nxt.r_nv = sh_nv - {1'b0, d_in.dn};
      nxt.q_nv = {d_in.q_nv[QN-2:0], 1'b1};
    end else begin
      nxt.r_nv = sh_nv;
      nxt.q_nv = {d_in.q_nv[QN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= nxt;
    end
  end

endmodule
`default_nettype wire
